/* sv/msort_pkg.sv */
// Shared types and constants for the merge sort engine.
// Holds the sequencer state enum and the control/status structs of the merge unit.
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RUN,
    S_FETCH_L,
    S_FETCH_R,
    S_WAIT_R,
    S_MERGE,
    S_REFILL_L,
    S_REFILL_R,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } state_e;

  typedef struct packed {
    logic load_l;   // capture read data as the left head
    logic load_r;   // capture read data as the right head
    logic l_avail;  // left run still has elements
    logic r_avail;  // right run still has elements
  } merge_ctrl_t;

  typedef struct packed {
    logic                     take_left;
    logic signed [DATA_W-1:0] winner;
  } merge_stat_t;

endpackage

`default_nettype wire

/* sv/msort_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/msort_merge.sv */
// Merge unit: left and right head registers and the shared signed comparator.
// Depends on msort_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module msort_merge (
  input  wire logic                                clk_i,
  input  wire msort_pkg::merge_ctrl_t              ctrl_i,
  input  wire logic signed [msort_pkg::DATA_W-1:0] rdata_i,
  output msort_pkg::merge_stat_t                   stat_o
);

  logic signed [msort_pkg::DATA_W-1:0] lhead_q;
  logic signed [msort_pkg::DATA_W-1:0] rhead_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_l) begin
      lhead_q <= rdata_i;
    end
    if (ctrl_i.load_r) begin
      rhead_q <= rdata_i;
    end
  end

  // Ties go to the left run so that the merge stays stable.
  always_comb begin
    stat_o.take_left = ctrl_i.l_avail && (!ctrl_i.r_avail || (lhead_q <= rhead_q));
    stat_o.winner    = stat_o.take_left ? lhead_q : rhead_q;
  end

endmodule

`default_nettype wire

/* sv/merge_sort_engine.sv */
// Merge sort engine top level: load sequencer, bottom-up merge passes, output stage.
// Depends on msort_pkg, msort_ram and msort_merge.
//
// Usage: values stream in on the s_axis channel, one signed 32-bit value per
// beat. The beat with tlast high closes the set; up to CAPACITY values are
// kept and beats beyond that are dropped (a dropped tlast beat still closes
// the set). The block then sorts ascending and streams every stored value on
// the m_axis channel, tlast high on the final one, after which it takes a new
// set.
// Throughput: loading accepts one beat per cycle. Sorting runs ceil(log2 n)
// passes over two ping-pong RAMs, all through one comparator. Each output
// beat goes through a RAM read, an output register load and the hand-off,
// which waits out any receiver stall; the next read starts after the hand-off.
// s_axis_tready is low from the closing beat until the last output beat is
// taken. A stalled receiver simply holds the output register; nothing is lost.
// Reset empties the store and returns to loading; RAM contents need no clear.
`timescale 1ns / 1ps
`default_nettype none

module merge_sort_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic             m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = CW + 2;
  localparam int unsigned DW = msort_pkg::DATA_W;

  msort_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] o_q, o_d;
  logic [IW-1:0] w_q, w_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [IW-1:0] hi_q, hi_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] k_q, k_d;
  logic          sel_q, sel_d;
  logic [DW-1:0] out_data_q;
  logic          out_last_q;

  logic [IW-1:0] n_ext;
  logic [IW-1:0] mid_sum, hi_sum, i_inc, j_inc, k_inc, w_dbl;
  logic [CW-1:0] count_inc, o_inc;
  logic          in_beat, out_beat, store_room, run_done, pass_done, sort_done;

  logic          we0, we1;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata0, rdata1, rdata;

  msort_pkg::merge_ctrl_t mctrl;
  msort_pkg::merge_stat_t mstat;

  assign n_ext      = IW'(count_q);
  assign mid_sum    = lo_q + w_q;
  assign hi_sum     = lo_q + (w_q << 1);
  assign w_dbl      = w_q << 1;
  assign i_inc      = i_q + IW'(1);
  assign j_inc      = j_q + IW'(1);
  assign k_inc      = k_q + IW'(1);
  assign count_inc  = count_q + CW'(1);
  assign o_inc      = o_q + CW'(1);
  assign store_room = count_q < CW'(CAPACITY);
  assign in_beat    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat   = m_axis_tvalid_o && m_axis_tready_i;
  assign run_done   = k_inc == hi_q;
  assign pass_done  = hi_q == n_ext;
  assign sort_done  = w_dbl >= n_ext;
  assign rdata      = sel_q ? rdata1 : rdata0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msort_pkg::S_LOAD: begin
        if (in_beat && s_axis_tlast_i) begin
          // A single stored value needs no merging.
          if ((store_room ? count_inc : count_q) > CW'(1)) begin
            state_d = msort_pkg::S_RUN;
          end else begin
            state_d = msort_pkg::S_OUT_RD;
          end
        end
      end
      msort_pkg::S_RUN:      state_d = msort_pkg::S_FETCH_L;
      msort_pkg::S_FETCH_L:  state_d = msort_pkg::S_FETCH_R;
      msort_pkg::S_FETCH_R:  state_d = msort_pkg::S_WAIT_R;
      msort_pkg::S_WAIT_R:   state_d = msort_pkg::S_MERGE;
      msort_pkg::S_MERGE: begin
        if (run_done) begin
          if (pass_done && sort_done) begin
            state_d = msort_pkg::S_OUT_RD;
          end else begin
            state_d = msort_pkg::S_RUN;
          end
        end else if (mstat.take_left) begin
          state_d = msort_pkg::S_REFILL_L;
        end else begin
          state_d = msort_pkg::S_REFILL_R;
        end
      end
      msort_pkg::S_REFILL_L: state_d = msort_pkg::S_MERGE;
      msort_pkg::S_REFILL_R: state_d = msort_pkg::S_MERGE;
      msort_pkg::S_OUT_RD:   state_d = msort_pkg::S_OUT_LD;
      msort_pkg::S_OUT_LD:   state_d = msort_pkg::S_OUT_HOLD;
      msort_pkg::S_OUT_HOLD: begin
        if (out_beat) begin
          state_d = out_last_q ? msort_pkg::S_LOAD : msort_pkg::S_OUT_RD;
        end
      end
      default:               state_d = msort_pkg::S_LOAD;
    endcase
  end

  // Outputs of the sequencer: RAM ports, merge unit control, handshakes.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    we0             = 1'b0;
    we1             = 1'b0;
    waddr           = k_q[AW-1:0];
    wdata           = mstat.winner;
    raddr           = o_q[AW-1:0];
    mctrl.load_l    = 1'b0;
    mctrl.load_r    = 1'b0;
    mctrl.l_avail   = i_q < mid_q;
    mctrl.r_avail   = j_q < hi_q;
    unique case (state_q)
      msort_pkg::S_LOAD: begin
        s_axis_tready_o = 1'b1;
        we0             = in_beat && store_room;
        waddr           = count_q[AW-1:0];
        wdata           = s_axis_tdata_i;
      end
      msort_pkg::S_FETCH_L: raddr = i_q[AW-1:0];
      msort_pkg::S_FETCH_R: begin
        raddr        = j_q[AW-1:0];
        mctrl.load_l = 1'b1;
      end
      msort_pkg::S_WAIT_R:  mctrl.load_r = 1'b1;
      msort_pkg::S_MERGE: begin
        // Each pass writes into the RAM it did not read from.
        we0   = sel_q;
        we1   = !sel_q;
        raddr = mstat.take_left ? i_inc[AW-1:0] : j_inc[AW-1:0];
      end
      msort_pkg::S_REFILL_L: mctrl.load_l = 1'b1;
      msort_pkg::S_REFILL_R: mctrl.load_r = 1'b1;
      msort_pkg::S_OUT_HOLD: m_axis_tvalid_o = 1'b1;
      default: begin
      end
    endcase
  end

  // Index and pass bookkeeping.
  always_comb begin
    count_d = count_q;
    o_d     = o_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    sel_d   = sel_q;
    unique case (state_q)
      msort_pkg::S_LOAD: begin
        if (in_beat) begin
          if (store_room) begin
            count_d = count_inc;
          end
          if (s_axis_tlast_i) begin
            w_d   = IW'(1);
            lo_d  = '0;
            sel_d = 1'b0;
            o_d   = '0;
          end
        end
      end
      msort_pkg::S_RUN: begin
        mid_d = (mid_sum > n_ext) ? n_ext : mid_sum;
        hi_d  = (hi_sum > n_ext) ? n_ext : hi_sum;
        i_d   = lo_q;
        j_d   = (mid_sum > n_ext) ? n_ext : mid_sum;
        k_d   = lo_q;
      end
      msort_pkg::S_MERGE: begin
        k_d = k_inc;
        if (mstat.take_left) begin
          i_d = i_inc;
        end else begin
          j_d = j_inc;
        end
        if (run_done) begin
          if (pass_done) begin
            w_d   = w_dbl;
            lo_d  = '0;
            sel_d = !sel_q;
            o_d   = '0;
          end else begin
            lo_d = hi_q;
          end
        end
      end
      msort_pkg::S_OUT_HOLD: begin
        if (out_beat) begin
          o_d = o_inc;
          if (out_last_q) begin
            count_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msort_pkg::S_LOAD;
      count_q <= '0;
      o_q     <= '0;
      w_q     <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      o_q     <= o_d;
      w_q     <= w_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == msort_pkg::S_OUT_LD) begin
      out_data_q <= rdata;
      out_last_q <= o_inc == count_q;
    end
  end

  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tlast_o = out_last_q;

  msort_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  msort_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  msort_merge u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (mctrl),
    .rdata_i (rdata),
    .stat_o  (mstat)
  );

  // The input and output sides never hand off in the same cycle.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while output valid");

  // The element count never exceeds the store size.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  // A merge step always writes inside the current run.
  a_merge_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msort_pkg::S_MERGE |-> (k_q < hi_q) && (mctrl.l_avail || mctrl.r_avail))
    else $error("merge step outside its run");

  // After the final output beat the block is ready for a new set.
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && m_axis_tlast_o |=> s_axis_tready_o && (count_q == '0))
    else $error("block not reloading after final beat");

endmodule

`default_nettype wire
